// ----- design/tt2w_pkg.sv -----
// Shared types, constants and codes of the two-way transposition table.
package tt2w_pkg;

    // Set index width and derived sizes
    localparam int INDEX_BITS = 12;
    localparam int SETS       = 1 << INDEX_BITS;
    localparam int COUNT_BITS = 14;
    localparam int PRIO_BITS  = 12;

    // Saturation value of the fill counter
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Store action codes reported with each result
    typedef enum logic [2:0] {
        ACT_LOOKUP  = 3'd0,
        ACT_FILL    = 3'd1,
        ACT_UPDATE  = 3'd2,
        ACT_REPLACE = 3'd3,
        ACT_DROP    = 3'd4
    } t_action;

    // Request type codes
    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_ADD    = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECIDE
    } t_state;

    // One input item
    typedef struct packed {
        logic               req_type;
        logic        [31:0] hash_code;
        logic        [63:0] occupied_bits;
        logic        [63:0] black_bits;
        logic               side_to_move;
        logic signed [31:0] eval_score;
        logic        [7:0]  best_move;
        logic        [7:0]  search_turn;
        logic        [7:0]  search_depth;
        logic        [7:0]  node_kind;
    } t_request;

    // One result item
    typedef struct packed {
        logic                  hit;
        logic                  hit_way;
        logic signed [31:0]    found_score;
        logic        [7:0]     found_move;
        logic        [7:0]     found_turn;
        logic        [7:0]     found_depth;
        logic        [7:0]     found_kind;
        logic        [2:0]     store_action;
        logic [COUNT_BITS-1:0] key_count;
    } t_result;

    // One stored way entry
    typedef struct packed {
        logic        [63:0] occupied;
        logic        [63:0] black;
        logic signed [31:0] score;
        logic        [7:0]  move;
        logic        [7:0]  kind;
        logic        [7:0]  turn;
        logic        [7:0]  depth;
        logic               side;
    } t_entry;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_we;
        logic capture;
        logic decide;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;
    } t_status;

endpackage

// ----- design/tt2w_ctrl.sv -----
// Controller state machine: clearing pass, idle and decide/write-back.
module tt2w_ctrl
    import tt2w_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    busy
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_we = 1'b1;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/tt2w_datapath.sv -----
// Datapath: way memories, key match, replacement choice and result register.
module tt2w_datapath
    import tt2w_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cmd     i_cmd,
    input  t_request i_request,
    output t_status  o_status,
    output logic     o_done,
    output t_result  o_result
);

    // Way memories
    t_entry r_mem0 [SETS];
    t_entry r_mem1 [SETS];

    t_request              r_req;
    t_entry                r_rd0;
    t_entry                r_rd1;
    logic [INDEX_BITS-1:0] r_clr_idx;
    logic [COUNT_BITS-1:0] r_key_count;
    logic [COUNT_BITS-1:0] n_key_count;
    logic                  r_done;
    t_result               r_result;
    t_result               n_result;

    logic [INDEX_BITS-1:0] rd_idx;
    logic [INDEX_BITS-1:0] wr_idx;
    t_entry                wr_entry;
    t_entry                new_entry;
    logic                  we0;
    logic                  we1;
    logic                  dec_we0;
    logic                  dec_we1;
    logic                  empty0;
    logic                  empty1;
    logic                  match0;
    logic                  match1;
    logic signed [PRIO_BITS-1:0] prio0;
    logic signed [PRIO_BITS-1:0] prio1;

    // Key match of one stored way against the request
    function automatic logic key_match(input t_entry e, input t_request q);
        return (e.occupied != 64'd0) && (e.occupied == q.occupied_bits) &&
               (e.black == q.black_bits) && (e.side == q.side_to_move);
    endfunction

    // Replacement priority: 4 * turn difference + depth difference
    function automatic logic signed [PRIO_BITS-1:0] way_prio(input t_entry e,
                                                             input t_request q);
        logic signed [PRIO_BITS-1:0] dt;
        logic signed [PRIO_BITS-1:0] dd;
        dt = $signed({{(PRIO_BITS-8){1'b0}}, q.search_turn}) -
             $signed({{(PRIO_BITS-8){1'b0}}, e.turn});
        dd = $signed({{(PRIO_BITS-8){1'b0}}, q.search_depth}) -
             $signed({{(PRIO_BITS-8){1'b0}}, e.depth});
        return (dt <<< 2) + dd;
    endfunction

    assign rd_idx = i_request.hash_code[INDEX_BITS-1:0];

    // Request register, loaded on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_request;
        end
    end

    // Clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear_we) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    assign o_status.clear_last = (r_clr_idx == '1);

    // Entry built from the request
    always_comb begin
        new_entry.occupied = r_req.occupied_bits;
        new_entry.black    = r_req.black_bits;
        new_entry.score    = r_req.eval_score;
        new_entry.move     = r_req.best_move;
        new_entry.kind     = r_req.node_kind;
        new_entry.turn     = r_req.search_turn;
        new_entry.depth    = r_req.search_depth;
        new_entry.side     = r_req.side_to_move;
    end

    // Match, empty and priority of both ways
    assign empty0 = (r_rd0.occupied == 64'd0);
    assign empty1 = (r_rd1.occupied == 64'd0);
    assign match0 = key_match(r_rd0, r_req);
    assign match1 = key_match(r_rd1, r_req);
    assign prio0  = way_prio(r_rd0, r_req);
    assign prio1  = way_prio(r_rd1, r_req);

    // Decision and next result
    always_comb begin
        n_result           = '0;
        n_result.key_count = r_key_count;
        n_key_count        = r_key_count;
        dec_we0            = 1'b0;
        dec_we1            = 1'b0;
        if (r_req.req_type == REQ_LOOKUP) begin
            n_result.store_action = ACT_LOOKUP;
            if (match0 || match1) begin
                n_result.hit         = 1'b1;
                n_result.hit_way     = !match0;
                n_result.found_score = match0 ? r_rd0.score : r_rd1.score;
                n_result.found_move  = match0 ? r_rd0.move  : r_rd1.move;
                n_result.found_turn  = match0 ? r_rd0.turn  : r_rd1.turn;
                n_result.found_depth = match0 ? r_rd0.depth : r_rd1.depth;
                n_result.found_kind  = match0 ? r_rd0.kind  : r_rd1.kind;
            end
        end else begin
            priority if (empty0 || empty1) begin
                n_result.store_action = ACT_FILL;
                dec_we0 = empty0;
                dec_we1 = !empty0;
                if (r_key_count != COUNT_MAX) begin
                    n_key_count = r_key_count + 1'b1;
                end
                n_result.key_count = n_key_count;
            end else if (match0 || match1) begin
                n_result.store_action = ACT_UPDATE;
                dec_we0 = match0;
                dec_we1 = !match0;
            end else if (prio0 <= 0 && prio1 <= 0) begin
                n_result.store_action = ACT_DROP;
            end else begin
                n_result.store_action = ACT_REPLACE;
                dec_we0 = (prio0 >= prio1);
                dec_we1 = (prio0 < prio1);
            end
            n_result.hit_way = dec_we1;
        end
    end

    // Memory write port: clearing pass or write-back
    assign wr_idx   = i_cmd.clear_we ? r_clr_idx : r_req.hash_code[INDEX_BITS-1:0];
    assign wr_entry = i_cmd.clear_we ? '0 : new_entry;
    assign we0      = i_cmd.clear_we || (i_cmd.decide && dec_we0);
    assign we1      = i_cmd.clear_we || (i_cmd.decide && dec_we1);

    // Way memories, registered read at accept
    always_ff @(posedge i_clk) begin
        if (we0) begin
            r_mem0[wr_idx] <= wr_entry;
        end
        if (i_cmd.capture) begin
            r_rd0 <= r_mem0[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we1) begin
            r_mem1[wr_idx] <= wr_entry;
        end
        if (i_cmd.capture) begin
            r_rd1 <= r_mem1[rd_idx];
        end
    end

    // Fill counter and done strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
            r_done      <= 1'b0;
        end else begin
            r_done <= i_cmd.decide;
            if (i_cmd.decide) begin
                r_key_count <= n_key_count;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_result <= n_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ----- design/two_way_transposition_table.sv -----
// Top level of the two-way set-associative transposition table.
// o_done is registered from the decide state that follows the accepting edge.
// A new item is taken only after the read of both ways and the write-back of the last one.
// Reset: synchronous, active low; afterwards a clearing pass over all 4096 sets (one set
// per cycle) holds busy high. The receiver cannot stall; o_done is high for one cycle.
module two_way_transposition_table
    import tt2w_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_request i_request,
    output logic     busy,
    output logic     o_done,
    output t_result  o_result
);

    t_cmd    cmd;
    t_status status;

    // Sequencer
    tt2w_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy)
    );

    // Storage and decision logic
    tt2w_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_request (i_request),
        .o_status  (status),
        .o_done    (o_done),
        .o_result  (o_result)
    );

endmodule

// ----- design/tt2w_checker.sv -----
// Port-level checker of the transposition table and its bind.
module tt2w_checker
    import tt2w_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input logic     o_done,
    input t_result  o_result
);

    // Every accepted item yields its result strobe
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("result strobe missing after accepted item");

    // Busy while an item is in flight
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after accept");

    // Strobes never come in adjacent cycles
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // A hit only comes from a lookup
    a_hit_is_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.hit) |-> (o_result.store_action == ACT_LOOKUP))
        else $error("hit reported on an add item");

endmodule

bind two_way_transposition_table tt2w_checker u_checker (.*);

// ----- verif/tb_top.sv -----
// Self-checking testbench of the two-way set-associative transposition table.
`timescale 1ns / 100ps

module tb_top;
    import tt2w_pkg::*;

    localparam int NUM_RANDOM     = 1900;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int POOL_DEPTH     = 24;
    localparam int HOT_SETS       = 6;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start = 1'b0;
    t_request i_request = '0;
    logic     busy;
    logic     o_done;
    t_result  o_result;

    // Shadow copy of the table, kept in step with every accepted item
    t_entry                tt_mem [0:1][0:SETS-1];
    logic [COUNT_BITS-1:0] fill_count;

    // Results still owed by the block, oldest first
    t_result probe_results_q [$];

    int error_count = 0;
    int stall_cycles = 0;
    int action_tally [0:4];
    int hit_tally = 0;
    int sent_count = 0;

    two_way_transposition_table dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_request (i_request),
        .busy      (busy),
        .o_done    (o_done),
        .o_result  (o_result)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Table predictor
    // ---------------------------------------------------------------

    // A way matches only when it holds a board and the whole key agrees
    function automatic logic key_hits(t_entry e, t_request rq);
        return (e.occupied != '0) && (e.occupied == rq.occupied_bits) &&
               (e.black == rq.black_bits) && (e.side == rq.side_to_move);
    endfunction

    // Replacement priority: four per turn of recency plus one per ply of depth
    function automatic int age_priority(t_entry e, t_request rq);
        int dt;
        int dd;
        dt = int'(rq.search_turn) - int'(e.turn);
        dd = int'(rq.search_depth) - int'(e.depth);
        return 4 * dt + dd;
    endfunction

    function automatic t_result predict_probe(t_request rq);
        logic [INDEX_BITS-1:0] idx;
        logic                  m0;
        logic                  m1;
        int                    p0;
        int                    p1;
        int                    w;
        t_entry                e_in;
        t_result               r;
        idx = rq.hash_code[INDEX_BITS-1:0];
        m0  = key_hits(tt_mem[0][idx], rq);
        m1  = key_hits(tt_mem[1][idx], rq);
        r   = '0;
        w   = -1;
        e_in.occupied = rq.occupied_bits;
        e_in.black    = rq.black_bits;
        e_in.score    = rq.eval_score;
        e_in.move     = rq.best_move;
        e_in.kind     = rq.node_kind;
        e_in.turn     = rq.search_turn;
        e_in.depth    = rq.search_depth;
        e_in.side     = rq.side_to_move;
        if (rq.req_type == REQ_LOOKUP) begin
            r.store_action = ACT_LOOKUP;
            if (m0 || m1) begin
                w             = m0 ? 0 : 1;
                r.hit         = 1'b1;
                r.hit_way     = w[0];
                r.found_score = tt_mem[w][idx].score;
                r.found_move  = tt_mem[w][idx].move;
                r.found_turn  = tt_mem[w][idx].turn;
                r.found_depth = tt_mem[w][idx].depth;
                r.found_kind  = tt_mem[w][idx].kind;
                hit_tally++;
            end
        end else begin
            if (tt_mem[0][idx].occupied == '0 || tt_mem[1][idx].occupied == '0) begin
                w              = (tt_mem[0][idx].occupied == '0) ? 0 : 1;
                r.store_action = ACT_FILL;
                if (fill_count != COUNT_MAX)
                    fill_count++;
            end else if (m0 || m1) begin
                w              = m0 ? 0 : 1;
                r.store_action = ACT_UPDATE;
            end else begin
                p0 = age_priority(tt_mem[0][idx], rq);
                p1 = age_priority(tt_mem[1][idx], rq);
                if (p0 <= 0 && p1 <= 0) begin
                    r.store_action = ACT_DROP;
                end else begin
                    w              = (p0 >= p1) ? 0 : 1;
                    r.store_action = ACT_REPLACE;
                end
            end
            if (w >= 0)
                tt_mem[w][idx] = e_in;
            r.hit_way = (w == 1);
        end
        r.key_count = fill_count;
        action_tally[r.store_action]++;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic t_request make_probe(logic req, logic [31:0] hash,
                                            logic [63:0] occ, logic [63:0] blk,
                                            logic side, logic [31:0] score,
                                            logic [7:0] move, logic [7:0] turn,
                                            logic [7:0] depth, logic [7:0] kind);
        t_request rq;
        rq.req_type      = req;
        rq.hash_code     = hash;
        rq.occupied_bits = occ;
        rq.black_bits    = blk;
        rq.side_to_move  = side;
        rq.eval_score    = score;
        rq.best_move     = move;
        rq.search_turn   = turn;
        rq.search_depth  = depth;
        rq.node_kind     = kind;
        return rq;
    endfunction

    function automatic t_request random_request();
        t_request rq;
        rq.req_type      = 1'($urandom_range(0, 1));
        rq.hash_code     = $urandom;
        rq.occupied_bits = {$urandom, $urandom};
        rq.black_bits    = {$urandom, $urandom};
        rq.side_to_move  = 1'($urandom_range(0, 1));
        rq.eval_score    = $urandom;
        rq.best_move     = 8'($urandom_range(0, 255));
        rq.search_turn   = 8'($urandom_range(0, 255));
        rq.search_depth  = 8'($urandom_range(0, 255));
        rq.node_kind     = 8'($urandom_range(0, 255));
        return rq;
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Present one item, wait for its acceptance, then idle for gap cycles
    task automatic send_probe(input t_request rq, input int gap);
        @(negedge i_clk);
        start     <= 1'b1;
        i_request <= rq;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        probe_results_q.push_back(predict_probe(rq));
        sent_count++;
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, field, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_done === 1'b1) begin
            if (probe_results_q.size() == 0) begin
                $display("%0t ns: result strobe with no item outstanding, actual %0h",
                         $time, o_result);
                error_count++;
            end else begin
                want = probe_results_q.pop_front();
                check_field("hit", 64'(want.hit), 64'(o_result.hit));
                check_field("hit_way", 64'(want.hit_way), 64'(o_result.hit_way));
                check_field("found_score", 64'($unsigned(want.found_score)),
                            64'($unsigned(o_result.found_score)));
                check_field("found_move", 64'(want.found_move),
                            64'(o_result.found_move));
                check_field("found_turn", 64'(want.found_turn),
                            64'(o_result.found_turn));
                check_field("found_depth", 64'(want.found_depth),
                            64'(o_result.found_depth));
                check_field("found_kind", 64'(want.found_kind),
                            64'(o_result.found_kind));
                check_field("store_action", 64'(want.store_action),
                            64'(o_result.store_action));
                check_field("key_count", 64'(want.key_count),
                            64'(o_result.key_count));
            end
        end
    end

    // Watchdog: no acceptance and no result for too long ends the run
    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_done === 1'b1)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("[two_way_transposition_table] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Lookups on empty sets never hit, not even for an all-zero board
    task automatic test_empty_lookups;
        send_probe(make_probe(REQ_LOOKUP, 32'h0, '0, '0, 1'b0, 32'h0, 8'h0, 8'h0,
                              8'h0, 8'h0), pick_gap());
        send_probe(make_probe(REQ_LOOKUP, 32'hFFFF_FFFF, '1, '1, 1'b1, 32'hFFFF_FFFF,
                              8'hFF, 8'hFF, 8'hFF, 8'hFF), pick_gap());
        send_probe(make_probe(REQ_LOOKUP, 32'h1234_5A5A, 64'h0000_0018_1800_0000,
                              64'h0000_0008_1000_0000, 1'b0, 32'h0, 8'h0, 8'h0,
                              8'h0, 8'h0), pick_gap());
    endtask

    // Fill both ways of set 0, hit each, miss on near keys, update in place
    task automatic test_fill_and_update;
        send_probe(make_probe(REQ_ADD, 32'h0, 64'h0000_0018_1800_0000,
                              64'h0000_0008_1000_0000, 1'b0, 32'h8000_0000, 8'h00,
                              8'h00, 8'h00, 8'h00), pick_gap());
        send_probe(make_probe(REQ_ADD, 32'hFFFF_F000, '1, '1, 1'b1, 32'h7FFF_FFFF,
                              8'hFF, 8'hFF, 8'hFF, 8'hFF), pick_gap());
        send_probe(make_probe(REQ_LOOKUP, 32'h0, 64'h0000_0018_1800_0000,
                              64'h0000_0008_1000_0000, 1'b0, 32'h0, 8'h0, 8'h0,
                              8'h0, 8'h0), pick_gap());
        send_probe(make_probe(REQ_LOOKUP, 32'hABCD_E000, '1, '1, 1'b1, 32'h0, 8'h0,
                              8'h0, 8'h0, 8'h0), pick_gap());
        // wrong side to move, then one black stone off
        send_probe(make_probe(REQ_LOOKUP, 32'h0, '1, '1, 1'b0, 32'h0, 8'h0, 8'h0,
                              8'h0, 8'h0), pick_gap());
        send_probe(make_probe(REQ_LOOKUP, 32'h0, 64'h0000_0018_1800_0000,
                              64'h0000_0008_1000_0001, 1'b0, 32'h0, 8'h0, 8'h0,
                              8'h0, 8'h0), pick_gap());
        send_probe(make_probe(REQ_ADD, 32'h0, '1, '1, 1'b1, 32'hDEAD_BEEF, 8'h2C,
                              8'd10, 8'd5, 8'h03), pick_gap());
        send_probe(make_probe(REQ_LOOKUP, 32'h0, '1, '1, 1'b1, 32'h0, 8'h0, 8'h0,
                              8'h0, 8'h0), pick_gap());
    endtask

    // Priority replacement and drops on a full set
    task automatic test_replacement;
        // set 0 holds (turn 0, depth 0) in way 0 and (10, 5) in way 1
        send_probe(make_probe(REQ_ADD, 32'h0, 64'h8000_0000_0000_0001, '0, 1'b0,
                              32'h1, 8'h1, 8'd0, 8'd0, 8'h1), pick_gap());
        send_probe(make_probe(REQ_ADD, 32'h0, 64'h8000_0000_0000_0001, '0, 1'b0,
                              32'h2, 8'h2, 8'd20, 8'd3, 8'h2), pick_gap());
        send_probe(make_probe(REQ_ADD, 32'h0, 64'h0000_0018_1C00_0000,
                              64'h0000_0000_0C00_0000, 1'b1, 32'h3, 8'h3, 8'd10,
                              8'd5, 8'h3), pick_gap());
        send_probe(make_probe(REQ_ADD, 32'h0, 64'h0000_0018_1C00_0000,
                              64'h0000_0000_0C00_0000, 1'b1, 32'h4, 8'h4, 8'd12,
                              8'd9, 8'h4), pick_gap());
        send_probe(make_probe(REQ_LOOKUP, 32'h0, 64'h0000_0018_1800_0000,
                              64'h0000_0008_1000_0000, 1'b0, 32'h0, 8'h0, 8'h0,
                              8'h0, 8'h0), pick_gap());
        send_probe(make_probe(REQ_LOOKUP, 32'h0, 64'h8000_0000_0000_0001, '0, 1'b0,
                              32'h0, 8'h0, 8'h0, 8'h0, 8'h0), pick_gap());
        // set FFF with equal ages: zero priorities drop, equal gains pick way 0
        send_probe(make_probe(REQ_ADD, 32'hFFFF_FFFF, 64'h0000_0000_0000_0F00, '0,
                              1'b0, 32'h5, 8'h5, 8'd50, 8'd7, 8'h5), pick_gap());
        send_probe(make_probe(REQ_ADD, 32'hFFFF_FFFF, 64'h0000_0000_00F0_0000, '0,
                              1'b1, 32'h6, 8'h6, 8'd50, 8'd7, 8'h6), pick_gap());
        send_probe(make_probe(REQ_ADD, 32'hFFFF_FFFF, 64'h0F00_0000_0000_0000, '1,
                              1'b0, 32'h7, 8'h7, 8'd50, 8'd7, 8'h7), pick_gap());
        send_probe(make_probe(REQ_ADD, 32'hFFFF_FFFF, 64'h0F00_0000_0000_0000, '1,
                              1'b0, 32'h7, 8'h7, 8'd51, 8'd0, 8'h7), pick_gap());
        send_probe(make_probe(REQ_ADD, 32'hFFFF_FFFF, 64'h0F00_0000_0000_0000, '1,
                              1'b0, 32'h7, 8'h7, 8'd52, 8'd7, 8'h7), pick_gap());
    endtask

    // An all-zero board counts as a fill yet leaves the way empty
    task automatic test_zero_board;
        send_probe(make_probe(REQ_LOOKUP, 32'h5, '0, '0, 1'b0, 32'h0, 8'h0, 8'h0,
                              8'h0, 8'h0), pick_gap());
        send_probe(make_probe(REQ_ADD, 32'h5, '0, 64'h00FF, 1'b0, 32'h11, 8'h11,
                              8'h11, 8'h11, 8'h11), pick_gap());
        send_probe(make_probe(REQ_LOOKUP, 32'h5, '0, 64'h00FF, 1'b0, 32'h0, 8'h0,
                              8'h0, 8'h0, 8'h0), pick_gap());
        send_probe(make_probe(REQ_ADD, 32'h5, '0, '0, 1'b1, 32'h22, 8'h22, 8'h22,
                              8'h22, 8'h22), pick_gap());
    endtask

    // Search-like traffic: a few hot sets, a pool of recurring positions
    task automatic test_random_traffic;
        logic [INDEX_BITS-1:0] hot_sets [0:HOT_SETS-1];
        t_request              key_pool [$];
        t_request              rq;
        t_request              known;
        logic [7:0]            game_turn;
        int                    sel;
        bit                    calm;
        for (int h = 0; h < HOT_SETS; h++)
            hot_sets[h] = INDEX_BITS'($urandom_range(0, SETS - 1));
        for (int i = 0; i < NUM_RANDOM; i++) begin
            calm        = ((i / 150) % 3 == 2);
            game_turn   = 8'(i / 16);
            rq          = random_request();
            rq.req_type = ($urandom_range(0, 99) < 45) ? REQ_LOOKUP : REQ_ADD;
            sel         = $urandom_range(0, 99);
            if (sel >= 8) begin
                rq.hash_code[INDEX_BITS-1:0] = hot_sets[$urandom_range(0, HOT_SETS - 1)];
                if (sel < 14) begin
                    rq.occupied_bits = '0;
                end else if (sel < 70 && key_pool.size() > 0) begin
                    known = key_pool[$urandom_range(0, key_pool.size() - 1)];
                    rq.hash_code[INDEX_BITS-1:0] = known.hash_code[INDEX_BITS-1:0];
                    rq.occupied_bits = known.occupied_bits;
                    rq.black_bits    = known.black_bits;
                    rq.side_to_move  = known.side_to_move;
                    // near miss on an otherwise known position
                    if ($urandom_range(0, 9) == 0)
                        rq.black_bits[$urandom_range(0, 63)] ^= 1'b1;
                    else if ($urandom_range(0, 19) == 0)
                        rq.side_to_move = ~rq.side_to_move;
                end else begin
                    if (key_pool.size() >= POOL_DEPTH)
                        void'(key_pool.pop_front());
                    key_pool.push_back(rq);
                end
            end
            // half the items follow a slowly advancing game clock
            if ($urandom_range(0, 1)) begin
                rq.search_turn  = game_turn + 8'($urandom_range(0, 3)) - 8'd1;
                rq.search_depth = 8'($urandom_range(0, 12));
            end
            send_probe(rq, calm ? 0 : pick_gap());
        end
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        for (int s = 0; s < SETS; s++) begin
            tt_mem[0][s] = '0;
            tt_mem[1][s] = '0;
        end
        fill_count = '0;
        for (int a = 0; a <= 4; a++)
            action_tally[a] = 0;

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_lookups();
        test_fill_and_update();
        test_replacement();
        test_zero_board();
        test_random_traffic();

        @(negedge i_clk);
        start <= 1'b0;
        while (probe_results_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d items: %0d lookups with %0d hits, %0d fills, %0d updates,",
                 sent_count, action_tally[ACT_LOOKUP], hit_tally, action_tally[ACT_FILL],
                 action_tally[ACT_UPDATE]);
        $display("%0d replacements, %0d drops; fill counter ended at %0d, %0d mismatches",
                 action_tally[ACT_REPLACE], action_tally[ACT_DROP], fill_count,
                 error_count);
        if (error_count == 0)
            $display("[two_way_transposition_table] OK");
        else
            $display("[two_way_transposition_table] ERROR");
        $finish;
    end

endmodule
